### src/srd_pkg.sv
// Package for the SLIP response deframer: parser states, result codes,
// framing byte constants and the result record type. No dependencies.
package srd_pkg;

  localparam logic [7:0] BYTE_END     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_END = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;
  localparam logic [7:0] BYTE_VERSION = 8'h00;
  localparam logic [6:0] CMD_RESET    = 7'h7F;
  localparam logic [7:0] CODE_RESET   = 8'hFF;

  typedef enum logic [2:0] {
    ST_END     = 3'd0,
    ST_HEADER  = 3'd1,
    ST_VERSION = 3'd2,
    ST_COMMAND = 3'd3,
    ST_CODE    = 3'd4,
    ST_LENGTH  = 3'd5,
    ST_DATA    = 3'd6,
    ST_ERROR   = 3'd7
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_START_MID   = 3'd1,
    ERR_DOUBLE_ESC  = 3'd2,
    ERR_BAD_VERSION = 3'd3,
    ERR_CMD_MSB     = 3'd4,
    ERR_NOT_START   = 3'd5,
    ERR_EXCESS      = 3'd6
  } error_kind_t;

  typedef struct packed {
    result_kind_t kind;
    logic [7:0]   data_byte;
    logic [6:0]   command;
    logic [7:0]   status_code;
    logic         last;
    error_kind_t  error_kind;
  } result_t;

endpackage

### src/slip_response_deframer.sv
// SLIP response deframer top level: unescapes the received byte stream,
// parses the response header and passes on payload bytes and error reports.
// Depends on srd_pkg for states, result codes and the result record.
//
//   channel | direction | ports                                   | per transaction
//   in      | input     | in_valid, in_stall, in_rx_byte          | one raw byte
//   out     | output    | out_valid, out_stall, out_kind .. error | zero or one result
//
// One byte is accepted per cycle while in_stall is low; its result, if any,
// goes to the output register, or to the skid register if the output register
// is held. A two-entry output stage (output register plus skid register) keeps
// a full-rate stream going; in_stall is registered and rises only while the
// skid register holds a result. rst_n is synchronous: the parser returns to
// the end state awaiting a start byte and both output entries are emptied.
module slip_response_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [6:0] out_command,
  output logic [7:0] out_status_code,
  output logic       out_last,
  output logic [2:0] out_error_kind
);

  srd_pkg::parse_state_t state_r, state_nxt;
  logic       esc_r, esc_nxt;
  logic [6:0] cmd_r, cmd_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  srd_pkg::result_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;
  logic res_valid;

  logic       in_accept, out_fire;
  logic       is_start, is_esc;
  logic [7:0] unesc;
  logic [7:0] cnt_inc;
  srd_pkg::parse_state_t eff_state;

  assign in_accept = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;

  assign is_start = (in_rx_byte == srd_pkg::BYTE_END);
  assign is_esc   = (in_rx_byte == srd_pkg::BYTE_ESC);
  assign cnt_inc  = cnt_r + 8'd1;

  always_comb begin
    unesc = in_rx_byte;
    if (esc_r && in_rx_byte == srd_pkg::BYTE_ESC_END) begin
      unesc = srd_pkg::BYTE_END;
    end else if (esc_r && in_rx_byte == srd_pkg::BYTE_ESC_ESC) begin
      unesc = srd_pkg::BYTE_ESC;
    end
  end

  // A start byte always restarts the header, whatever the parser was doing.
  assign eff_state = is_start ? srd_pkg::ST_HEADER : state_r;

  // Next state of the parser and its header registers.
  always_comb begin
    state_nxt = state_r;
    esc_nxt   = esc_r;
    cmd_nxt   = cmd_r;
    code_nxt  = code_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    if (is_esc) begin
      if (esc_r) begin
        state_nxt = srd_pkg::ST_ERROR;
      end else begin
        esc_nxt = 1'b1;
      end
    end else begin
      if (is_start || unesc != in_rx_byte) begin
        esc_nxt = 1'b0;
      end
      case (eff_state)
        srd_pkg::ST_HEADER: begin
          if (unesc != srd_pkg::BYTE_END) begin
            state_nxt = srd_pkg::ST_ERROR;
          end else begin
            cmd_nxt   = srd_pkg::CMD_RESET;
            code_nxt  = srd_pkg::CODE_RESET;
            len_nxt   = 8'd0;
            cnt_nxt   = 8'd0;
            state_nxt = srd_pkg::ST_VERSION;
          end
        end
        srd_pkg::ST_VERSION: begin
          state_nxt = (unesc == srd_pkg::BYTE_VERSION) ? srd_pkg::ST_COMMAND
                                                       : srd_pkg::ST_ERROR;
        end
        srd_pkg::ST_COMMAND: begin
          if (!unesc[7]) begin
            state_nxt = srd_pkg::ST_ERROR;
          end else begin
            cmd_nxt   = unesc[6:0];
            state_nxt = srd_pkg::ST_CODE;
          end
        end
        srd_pkg::ST_CODE: begin
          code_nxt  = unesc;
          state_nxt = srd_pkg::ST_LENGTH;
        end
        srd_pkg::ST_LENGTH: begin
          len_nxt   = unesc;
          state_nxt = (unesc == 8'd0) ? srd_pkg::ST_END : srd_pkg::ST_DATA;
        end
        srd_pkg::ST_DATA: begin
          if (cnt_r >= len_r) begin
            state_nxt = srd_pkg::ST_ERROR;
          end else begin
            cnt_nxt = cnt_inc;
            if (cnt_inc == len_r) begin
              state_nxt = srd_pkg::ST_END;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result of the byte; every result carries the command and code held
  // before this byte is taken in.
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = srd_pkg::KIND_ERROR;
    res.data_byte   = 8'd0;
    res.command     = cmd_r;
    res.status_code = code_r;
    res.last        = 1'b0;
    res.error_kind  = srd_pkg::ERR_NONE;
    if (is_esc) begin
      res_valid      = esc_r;
      res.error_kind = srd_pkg::ERR_DOUBLE_ESC;
    end else if (is_start) begin
      res_valid      = !(state_r inside {srd_pkg::ST_END, srd_pkg::ST_ERROR});
      res.error_kind = srd_pkg::ERR_START_MID;
    end else begin
      case (state_r)
        srd_pkg::ST_HEADER: begin
          res_valid      = (unesc != srd_pkg::BYTE_END);
          res.error_kind = srd_pkg::ERR_NOT_START;
        end
        srd_pkg::ST_VERSION: begin
          res_valid      = (unesc != srd_pkg::BYTE_VERSION);
          res.error_kind = srd_pkg::ERR_BAD_VERSION;
        end
        srd_pkg::ST_COMMAND: begin
          res_valid      = !unesc[7];
          res.error_kind = srd_pkg::ERR_CMD_MSB;
        end
        srd_pkg::ST_LENGTH: begin
          res_valid = (unesc == 8'd0);
          res.kind  = srd_pkg::KIND_EMPTY;
          res.last  = 1'b1;
        end
        srd_pkg::ST_DATA: begin
          res_valid = 1'b1;
          if (cnt_r >= len_r) begin
            res.error_kind = srd_pkg::ERR_EXCESS;
          end else begin
            res.kind      = srd_pkg::KIND_DATA;
            res.data_byte = unesc;
            res.last      = (cnt_inc == len_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srd_pkg::ST_END;
      esc_r   <= 1'b0;
      cmd_r   <= srd_pkg::CMD_RESET;
      code_r  <= srd_pkg::CODE_RESET;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (in_accept) begin
      state_r <= state_nxt;
      esc_r   <= esc_nxt;
      cmd_r   <= cmd_nxt;
      code_r  <= code_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign in_stall        = skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_r.kind;
  assign out_data_byte   = out_r.data_byte;
  assign out_command     = out_r.command;
  assign out_status_code = out_r.status_code;
  assign out_last        = out_r.last;
  assign out_error_kind  = out_r.error_kind;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_no_header_rest: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != srd_pkg::ST_HEADER)
    else $error("parser settled in the header state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srd_pkg::ST_DATA |-> cnt_r < len_r)
    else $error("payload count reached the length without leaving the data state");

  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind == srd_pkg::KIND_ERROR
      |-> !out_r.last && out_r.error_kind != srd_pkg::ERR_NONE)
    else $error("error report with last set or without an error code");

  a_stall_after_skid: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && res_valid && out_valid_r && out_stall && !skid_valid_r
      |=> in_stall)
    else $error("input not stalled after the skid entry filled");
`endif

endmodule

### test/tb_top.sv
// Self-checking testbench for slip_response_deframer: drives escaped byte streams and
// checks every result against a byte-level deframing predictor kept in this file.
// Depends on srd_pkg for parser states, result codes, framing bytes and result_t.
module tb_top;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_data_byte;
  logic [6:0] out_command;
  logic [7:0] out_status_code;
  logic       out_last;
  logic [2:0] out_error_kind;

  // Predictor state.
  srd_pkg::parse_state_t pstate;
  logic                  escaped;
  logic [7:0]            cmd_q;
  logic [7:0]            code_q;
  logic [7:0]            len_q;
  logic [7:0]            count_q;
  srd_pkg::result_t      deframed_results[$];

  int bytes_sent;
  int mismatches;
  int quiet_cycles;
  int hold_request;
  bit tx_idle_en;
  bit rx_idle_en;

  slip_response_deframer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_command     (out_command),
    .out_status_code (out_status_code),
    .out_last        (out_last),
    .out_error_kind  (out_error_kind)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic srd_pkg::result_t make_result(input srd_pkg::result_kind_t kind,
                                                   input logic [7:0] data,
                                                   input logic last,
                                                   input srd_pkg::error_kind_t err);
    srd_pkg::result_t r;
    r.kind        = kind;
    r.data_byte   = data;
    r.command     = cmd_q[6:0];
    r.status_code = code_q;
    r.last        = last;
    r.error_kind  = err;
    return r;
  endfunction

  function automatic void raise_error(input srd_pkg::error_kind_t err);
    deframed_results.push_back(make_result(srd_pkg::KIND_ERROR, 8'h00, 1'b0, err));
    pstate = srd_pkg::ST_ERROR;
  endfunction

  // Applies one raw byte to the predicted parser and queues any result it causes.
  function automatic void deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (raw == srd_pkg::BYTE_END) begin
      escaped = 1'b0;
      if (pstate != srd_pkg::ST_ERROR && pstate != srd_pkg::ST_END)
        deframed_results.push_back(make_result(srd_pkg::KIND_ERROR, 8'h00, 1'b0,
                                               srd_pkg::ERR_START_MID));
      pstate = srd_pkg::ST_HEADER;
    end else if (raw == srd_pkg::BYTE_ESC) begin
      // A second escape is an error, and the escape flag remains set afterwards.
      if (escaped)
        raise_error(srd_pkg::ERR_DOUBLE_ESC);
      escaped = 1'b1;
      return;
    end else if (raw == srd_pkg::BYTE_ESC_END && escaped) begin
      b = srd_pkg::BYTE_END;
      escaped = 1'b0;
    end else if (raw == srd_pkg::BYTE_ESC_ESC && escaped) begin
      b = srd_pkg::BYTE_ESC;
      escaped = 1'b0;
    end

    case (pstate)
      srd_pkg::ST_HEADER: begin
        if (b != srd_pkg::BYTE_END) begin
          raise_error(srd_pkg::ERR_NOT_START);
        end else begin
          cmd_q   = {1'b1, srd_pkg::CMD_RESET};
          code_q  = srd_pkg::CODE_RESET;
          len_q   = '0;
          count_q = '0;
          pstate  = srd_pkg::ST_VERSION;
        end
      end
      srd_pkg::ST_VERSION: begin
        if (b != srd_pkg::BYTE_VERSION) raise_error(srd_pkg::ERR_BAD_VERSION);
        else pstate = srd_pkg::ST_COMMAND;
      end
      srd_pkg::ST_COMMAND: begin
        if (!b[7]) begin
          raise_error(srd_pkg::ERR_CMD_MSB);
        end else begin
          cmd_q  = {1'b0, b[6:0]};
          pstate = srd_pkg::ST_CODE;
        end
      end
      srd_pkg::ST_CODE: begin
        code_q = b;
        pstate = srd_pkg::ST_LENGTH;
      end
      srd_pkg::ST_LENGTH: begin
        len_q  = b;
        pstate = srd_pkg::ST_DATA;
        if (b == '0) begin
          deframed_results.push_back(make_result(srd_pkg::KIND_EMPTY, 8'h00, 1'b1,
                                                 srd_pkg::ERR_NONE));
          pstate = srd_pkg::ST_END;
        end
      end
      srd_pkg::ST_DATA: begin
        if (count_q >= len_q) begin
          raise_error(srd_pkg::ERR_EXCESS);
        end else begin
          count_q = count_q + 8'd1;
          deframed_results.push_back(make_result(srd_pkg::KIND_DATA, b, count_q == len_q,
                                                 srd_pkg::ERR_NONE));
          if (count_q == len_q) pstate = srd_pkg::ST_END;
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one raw byte, waits for the transaction, and may then leave a gap.
  task automatic send_byte(input logic [7:0] value);
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    do @(posedge clk); while (in_stall);
    deframe_byte(value);
    bytes_sent++;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_escaped(input logic [7:0] value);
    if (value == srd_pkg::BYTE_END) begin
      send_byte(srd_pkg::BYTE_ESC);
      send_byte(srd_pkg::BYTE_ESC_END);
    end else if (value == srd_pkg::BYTE_ESC) begin
      send_byte(srd_pkg::BYTE_ESC);
      send_byte(srd_pkg::BYTE_ESC_ESC);
    end else begin
      send_byte(value);
    end
  endtask

  task automatic send_header(input logic [6:0] cmd, input logic [7:0] code,
                             input logic [7:0] len);
    send_byte(srd_pkg::BYTE_END);
    send_byte(srd_pkg::BYTE_VERSION);
    send_escaped({1'b1, cmd});
    send_escaped(code);
    send_escaped(len);
  endtask

  // Payload bytes lean towards the framing values so that escaping is exercised often.
  function automatic logic [7:0] random_payload();
    case ($urandom_range(0, 9))
      0:       return srd_pkg::BYTE_END;
      1:       return srd_pkg::BYTE_ESC;
      2:       return ($urandom_range(0, 1) == 0) ? srd_pkg::BYTE_ESC_END
                                                  : srd_pkg::BYTE_ESC_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_packet(input int len);
    send_header(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'(len));
    for (int i = 0; i < len; i++) send_escaped(random_payload());
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (deframed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_good_frames();
    send_header(7'h00, 8'h00, 8'd0);
    send_header(7'h7F, srd_pkg::BYTE_END, 8'd2);
    send_escaped(8'hFF);
    send_escaped(srd_pkg::BYTE_ESC);
    // Unescaped 0xDC and 0xDD are ordinary payload bytes.
    send_header(7'h40, 8'h7E, 8'd2);
    send_byte(srd_pkg::BYTE_ESC_END);
    send_byte(srd_pkg::BYTE_ESC_ESC);
  endtask

  task automatic test_escape_cases();
    send_byte(srd_pkg::BYTE_ESC);
    send_byte(srd_pkg::BYTE_ESC);
    send_byte(srd_pkg::BYTE_ESC_END);
    send_byte(srd_pkg::BYTE_ESC_ESC);
    // An escape before an ordinary byte stays pending across the header fields.
    send_byte(srd_pkg::BYTE_END);
    send_byte(srd_pkg::BYTE_VERSION);
    send_byte(8'h81);
    send_byte(srd_pkg::BYTE_ESC);
    send_byte(8'h41);
    send_byte(8'h01);
    send_byte(srd_pkg::BYTE_ESC_END);
    send_header(7'h2A, 8'h55, 8'd3);
    send_byte(8'h00);
    send_byte(srd_pkg::BYTE_ESC);
    send_byte(srd_pkg::BYTE_ESC);
    send_byte(8'h10);
  endtask

  task automatic test_header_errors();
    send_byte(srd_pkg::BYTE_END);
    send_byte(8'h01);
    send_byte(8'h33);
    send_byte(srd_pkg::BYTE_END);
    send_byte(srd_pkg::BYTE_VERSION);
    send_byte(8'h7F);
    send_header(7'h02, 8'h80, 8'd4);
    send_byte(8'h11);
    send_header(7'h03, 8'h04, 8'd0);
  endtask

  task automatic test_random_stream(input int num_bytes);
    int stop_at;
    stop_at = bytes_sent + num_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_idle_en = 1'($urandom_range(0, 1));
        rx_idle_en = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 80) begin
        send_random_packet(($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                         : $urandom_range(9, 40));
      end else begin
        case ($urandom_range(0, 5))
          0: begin
            // Truncated packet: the next start byte arrives mid-packet.
            send_header(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd5);
            repeat ($urandom_range(0, 4)) send_escaped(random_payload());
          end
          1: begin
            send_byte(srd_pkg::BYTE_END);
            send_byte(8'($urandom_range(1, 255)));
          end
          2: begin
            send_byte(srd_pkg::BYTE_END);
            send_byte(srd_pkg::BYTE_VERSION);
            send_byte(8'($urandom_range(0, 127)));
          end
          3: begin
            send_header(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd6);
            send_escaped(random_payload());
            send_byte(srd_pkg::BYTE_ESC);
            send_byte(srd_pkg::BYTE_ESC);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
          end
          4: begin
            send_header(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)), 8'd4);
            send_byte(srd_pkg::BYTE_ESC);
            repeat (4) send_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  // The receiver stops for a long stretch while a long packet keeps arriving,
  // then the sender pauses until every outstanding result has been delivered.
  task automatic test_receiver_hold();
    tx_idle_en   = 1'b0;
    hold_request = HOLD_CYCLES;
    send_random_packet(60);
    wait_until_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_full_rate(input int num_bytes);
    int stop_at;
    stop_at    = bytes_sent + num_bytes;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random_packet(255);
    while (bytes_sent < stop_at) send_random_packet($urandom_range(0, 8));
  endtask

  // Receiver: random stall bursts, or one long counted hold when requested.
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    srd_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d data=%h cmd=%h code=%h last=%b err=%0d",
                   out_kind, out_data_byte, out_command, out_status_code, out_last,
                   out_error_kind);
        mismatches++;
      end else begin
        want = deframed_results.pop_front();
        if (out_kind !== want.kind || out_data_byte !== want.data_byte ||
            out_command !== want.command || out_status_code !== want.status_code ||
            out_last !== want.last || out_error_kind !== want.error_kind) begin
          if (mismatches < 10) begin
            $display("mismatch expected: kind=%0d data=%h cmd=%h code=%h last=%b err=%0d",
                     want.kind, want.data_byte, want.command, want.status_code, want.last,
                     want.error_kind);
            $display("         actual:   kind=%0d data=%h cmd=%h code=%h last=%b err=%0d",
                     out_kind, out_data_byte, out_command, out_status_code, out_last,
                     out_error_kind);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_rx_byte   <= '0;
    quiet_cycles  = 0;
    mismatches    = 0;
    bytes_sent    = 0;
    hold_request  = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    pstate        = srd_pkg::ST_END;
    escaped       = 1'b0;
    cmd_q         = {1'b1, srd_pkg::CMD_RESET};
    code_q        = srd_pkg::CODE_RESET;
    len_q         = '0;
    count_q       = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_good_frames();
    test_escape_cases();
    test_header_errors();
    test_random_stream(850);
    test_receiver_hold();
    test_full_rate(330);

    in_valid <= 1'b0;
    while (deframed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && deframed_results.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
